@@ rtl/core/loss_and_gradient_unit_core_assert.svh @@
// Assertion macros shared by the loss and gradient unit RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef LOSS_AND_GRADIENT_UNIT_CORE_ASSERT_SVH
`define LOSS_AND_GRADIENT_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LGU_ASSERT_NOW(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LGU_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lgu_pkg.sv @@
// Types and constants of the loss and gradient unit.
// Depends on nothing; imported by every module of the unit.
`timescale 1ns / 1ps
`default_nettype none

package lgu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OutW  = 48;
  localparam int unsigned CntW  = 17;
  localparam int unsigned ModeW = 2;
  localparam int unsigned NumW  = 64;
  localparam int unsigned DenW  = 48;

  localparam logic [ModeW-1:0] ModeCe  = 2'd1;
  localparam logic [ModeW-1:0] ModeBce = 2'd2;

  localparam logic CfgLossMode  = 1'b0;
  localparam logic CfgElemCount = 1'b1;

  localparam logic signed [33:0] OneQ24 = 34'sd16777216;
  localparam logic signed [33:0] EpLsb  = 34'sd2;
  localparam logic [31:0]        Ln2Q32 = 32'd2977044472;
  localparam logic signed [63:0] OutMax = 64'sd140737488355327;
  localparam logic signed [63:0] OutMin = -64'sd140737488355328;

  typedef enum logic [1:0] {
    OP_MSE,
    OP_CE,
    OP_BCE
  } lgu_op_t;

  typedef struct packed {
    logic signed [DataW-1:0] target;
    logic signed [DataW-1:0] pred;
    logic                    fin;
    lgu_op_t                 op;
    logic [CntW-1:0]         count;
  } lgu_item_t;

  typedef struct packed {
    logic      push;
    lgu_item_t item;
  } lgu_push_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } lgu_div_req_t;

endpackage

`default_nettype wire

@@ rtl/core/lgu_front.sv @@
// Front end: configuration registers, input acceptance and classification.
// Depends on lgu_pkg; feeds lgu_queue.
`timescale 1ns / 1ps
`default_nettype none

module lgu_front #(
  parameter int unsigned MAX_ELEMENTS = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [lgu_pkg::CntW-1:0] cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [63:0]              in_tdata,
  input  logic                     in_tlast,
  input  logic                     q_full,
  output lgu_pkg::lgu_push_t       wr
);
  import lgu_pkg::*;

  localparam logic [24:0] MaxElem = 25'(MAX_ELEMENTS);

  logic [ModeW-1:0] mode_r;
  logic [CntW-1:0]  count_r;
  logic [CntW-1:0]  count_eff;
  lgu_op_t          op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      count_r <= CntW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgLossMode:  mode_r  <= cfg_wdata[ModeW-1:0];
        CfgElemCount: count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp N to [1, MAX_ELEMENTS]
  always_comb begin
    if (count_r == '0) begin
      count_eff = CntW'(1);
    end else if ({8'd0, count_r} > MaxElem) begin
      count_eff = MaxElem[CntW-1:0];
    end else begin
      count_eff = count_r;
    end
  end

  // Unused mode code falls back to mean square error
  always_comb begin
    unique case (mode_r)
      ModeCe:  op = OP_CE;
      ModeBce: op = OP_BCE;
      default: op = OP_MSE;
    endcase
  end

  assign in_tready       = !q_full;
  assign wr.push         = in_tvalid && !q_full;
  assign wr.item.target  = in_tdata[31:0];
  assign wr.item.pred    = in_tdata[63:32];
  assign wr.item.fin     = in_tlast;
  assign wr.item.op      = op;
  assign wr.item.count   = count_eff;

endmodule

`default_nettype wire

@@ rtl/core/lgu_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on lgu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "loss_and_gradient_unit_core_assert.svh"

module lgu_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  lgu_pkg::lgu_push_t wr,
  output logic               full,
  output logic               rd_valid,
  output lgu_pkg::lgu_item_t rd_item,
  input  logic               pop
);
  import lgu_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  lgu_item_t        mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [FillW-1:0] count_r;
  logic             push;

  assign push     = wr.push;
  assign full     = (count_r == FillW'(Depth));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + FillW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - FillW'(1);
      end
    end
  end

  `LGU_ASSERT_NOW(a_no_overflow, clk, rst_n, push && !pop, count_r != FillW'(Depth), "queue overflow")
  `LGU_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, count_r != '0, "pop from empty queue")
  `LGU_ASSERT_NEXT(a_fill_up, clk, rst_n, push && !pop, count_r == $past(count_r) + FillW'(1), "fill count lost a push")

endmodule

`default_nettype wire

@@ rtl/core/lgu_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on lgu_pkg; used by lgu_back.
`timescale 1ns / 1ps
`default_nettype none

module lgu_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lgu_pkg::lgu_div_req_t    req,
  output logic                     busy,
  output logic [lgu_pkg::NumW-1:0] quo
);
  import lgu_pkg::*;

  localparam int unsigned StepW = $clog2(NumW);

  logic [DenW-1:0]  rem_r;
  logic [DenW-1:0]  den_r;
  logic [NumW-1:0]  quo_r;
  logic [StepW-1:0] step_r;
  logic             busy_r;
  logic [DenW:0]    trial;
  logic [DenW:0]    diff;
  logic             ge;

  assign trial = {rem_r, quo_r[NumW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign busy  = busy_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      quo_r  <= req.num;
      den_r  <= req.den;
      rem_r  <= '0;
      step_r <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_r  <= {quo_r[NumW-2:0], ge};
      step_r <= step_r + StepW'(1);
      if (step_r == StepW'(NumW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lgu_back.sv @@
// Back end: sequencer with shared multiplier, logarithm steps, divider and accumulator.
// Depends on lgu_pkg, lgu_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "loss_and_gradient_unit_core_assert.svh"

module lgu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lgu_pkg::lgu_item_t q_item,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [95:0]        out_tdata,
  output logic               out_tuser,
  output logic               out_tlast
);
  import lgu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SQW, S_M1_GD, S_LNORM, S_LSQ, S_LCONV, S_LLN2,
    S_LRND, S_LMUL, S_LTERM, S_GWAIT, S_GWAIT2, S_ACC, S_CWAIT, S_OUT
  } state_t;

  function automatic logic signed [63:0] apply_sign(logic [63:0] m, logic neg);
    logic signed [63:0] v;
    v = signed'(m);
    return neg ? -v : v;
  endfunction

  function automatic logic [OutW-1:0] sat48(logic signed [63:0] v);
    logic [OutW-1:0] r;
    if (v > OutMax) begin
      r = OutMax[OutW-1:0];
    end else if (v < OutMin) begin
      r = OutMin[OutW-1:0];
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

  state_t             state_r;
  lgu_item_t          item_r;
  logic signed [63:0] term_r;
  logic signed [63:0] grad_r;
  logic signed [63:0] cost_sum_r;
  logic               csum_neg_r;
  logic [OutW-1:0]    cost_r;
  logic [63:0]        prod_r;
  logic [31:0]        lx_r;
  logic [4:0]         lk_r;
  logic [30:0]        lm_r;
  logic [23:0]        lfrac_r;
  logic [4:0]         lcnt_r;
  logic [29:0]        lmag_r;
  logic               lneg_r;
  logic               ljob_r;
  logic               out_valid_r;
  logic [95:0]        out_data_r;
  logic               out_last_r;

  logic signed [31:0] t_s;
  logic signed [31:0] p_s;
  logic signed [32:0] diff_tp;
  logic signed [32:0] diff_inv;
  logic [31:0]        abs_diff;
  logic signed [32:0] t_inv;
  logic [31:0]        t_mag;
  logic signed [33:0] p_ext;
  logic signed [33:0] omt;
  logic signed [33:0] omt_inv;
  logic [31:0]        omt_mag;
  logic               p_pos;
  logic [23:0]        pc;
  logic [23:0]        one_m_pc;
  logic signed [33:0] larg0_w;
  logic signed [33:0] larg1_w;
  logic [31:0]        larg0;
  logic [31:0]        larg1;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [31:0]        sq_top;
  logic signed [5:0]  k_off;
  logic signed [29:0] l_val;
  logic signed [29:0] l_inv;
  logic [31:0]        coef_mag;
  logic               coef_neg;
  logic signed [63:0] prod_q24;
  logic signed [64:0] sum_wide;
  logic signed [63:0] sum_nxt;
  logic signed [63:0] sum_inv;
  logic [63:0]        sum_mag;
  logic [63:0]        quo_neg;
  logic [OutW-1:0]    cost_nxt;
  lgu_div_req_t       div_req;
  logic               div_busy;
  logic [NumW-1:0]    div_quo;
  logic               out_load;

  assign t_s      = item_r.target;
  assign p_s      = item_r.pred;
  assign diff_tp  = {t_s[31], t_s} - {p_s[31], p_s};
  assign diff_inv = -diff_tp;
  assign abs_diff = diff_tp[32] ? diff_inv[31:0] : diff_tp[31:0];
  assign t_inv    = -{t_s[31], t_s};
  assign t_mag    = t_s[31] ? t_inv[31:0] : t_s[31:0];
  assign p_ext    = {{2{p_s[31]}}, p_s};
  assign omt      = OneQ24 - {{2{t_s[31]}}, t_s};
  assign omt_inv  = -omt;
  assign omt_mag  = omt[33] ? omt_inv[31:0] : omt[31:0];
  assign p_pos    = !p_s[31] && (p_s != '0);

  // Clamp p to [ep, 1-ep] for the binary cross entropy quotients
  always_comb begin
    if (p_s < 32'sd2) begin
      pc = 24'd2;
    end else if (p_s > 32'sd16777214) begin
      pc = 24'd16777214;
    end else begin
      pc = p_s[23:0];
    end
  end
  assign one_m_pc = 24'd0 - pc;

  // Log arguments; anything below 1 LSB is raised to 1 LSB
  assign larg0_w = p_ext + EpLsb;
  assign larg1_w = OneQ24 - p_ext + EpLsb;
  assign larg0   = (larg0_w < 34'sd1) ? 32'd1 : larg0_w[31:0];
  assign larg1   = (larg1_w < 34'sd1) ? 32'd1 : larg1_w[31:0];

  assign coef_mag = ljob_r ? omt_mag : t_mag;
  assign coef_neg = ljob_r ? omt[33] : t_s[31];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_PREP: begin
        if (item_r.op == OP_CE) begin
          mul_a = p_s[31:0];
          mul_b = {15'd0, item_r.count};
        end else begin
          mul_a = abs_diff;
          mul_b = abs_diff;
        end
      end
      S_LSQ: begin
        mul_a = {1'b0, lm_r};
        mul_b = {1'b0, lm_r};
      end
      S_LLN2: begin
        mul_a = {2'd0, lmag_r};
        mul_b = Ln2Q32;
      end
      S_LMUL: begin
        mul_a = coef_mag;
        mul_b = {2'd0, lmag_r};
      end
      default: ;
    endcase
  end
  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign sq_top = mul_p[61:30];

  assign k_off    = signed'({1'b0, lk_r}) - 6'sd24;
  assign l_val    = {k_off, lfrac_r};
  assign l_inv    = -l_val;
  assign prod_q24 = signed'({24'd0, prod_r[63:24]});

  // Saturating accumulation of this element's term
  assign sum_wide = {cost_sum_r[63], cost_sum_r} + {term_r[63], term_r};
  always_comb begin
    if (sum_wide[64] != sum_wide[63]) begin
      sum_nxt = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_nxt = sum_wide[63:0];
    end
  end
  assign sum_inv = -sum_nxt;
  assign sum_mag = sum_nxt[63] ? sum_inv : sum_nxt;

  assign quo_neg = 64'd0 - div_quo;
  always_comb begin
    if (!csum_neg_r) begin
      cost_nxt = (div_quo > 64'(OutMax)) ? OutMax[OutW-1:0] : div_quo[OutW-1:0];
    end else begin
      cost_nxt = (div_quo > 64'(-OutMin)) ? OutMin[OutW-1:0] : quo_neg[OutW-1:0];
    end
  end

  // Divider request select
  always_comb begin
    div_req = '0;
    case (state_r)
      S_PREP: begin
        if (item_r.op == OP_MSE) begin
          div_req.start = 1'b1;
          div_req.num   = {31'd0, abs_diff, 1'b0};
          div_req.den   = {31'd0, item_r.count};
        end else if (item_r.op == OP_BCE) begin
          div_req.start = 1'b1;
          div_req.num   = {8'd0, omt_mag, 24'd0};
          div_req.den   = {24'd0, one_m_pc};
        end
      end
      S_M1_GD: begin
        div_req.start = p_pos;
        div_req.num   = {8'd0, t_mag, 24'd0};
        div_req.den   = prod_r[DenW-1:0];
      end
      S_GWAIT: begin
        if (item_r.op == OP_BCE && !div_busy) begin
          div_req.start = 1'b1;
          div_req.num   = {8'd0, t_mag, 24'd0};
          div_req.den   = {24'd0, pc};
        end
      end
      S_ACC: begin
        if (item_r.fin) begin
          div_req.start = 1'b1;
          div_req.num   = sum_mag;
          div_req.den   = {31'd0, item_r.count};
        end
      end
      default: ;
    endcase
  end

  lgu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cost_sum_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            term_r  <= '0;
            ljob_r  <= 1'b0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          case (item_r.op)
            OP_CE:  state_r <= S_M1_GD;
            OP_BCE: begin
              lx_r    <= larg0;
              lk_r    <= 5'd31;
              state_r <= S_LNORM;
            end
            default: state_r <= S_SQW;
          endcase
        end
        S_SQW: begin
          term_r  <= prod_q24;
          state_r <= S_GWAIT;
        end
        S_M1_GD: begin
          lx_r    <= larg0;
          lk_r    <= 5'd31;
          state_r <= S_LNORM;
        end
        S_LNORM: begin
          if (lx_r[31]) begin
            lm_r    <= lx_r[31:1];
            lcnt_r  <= '0;
            lfrac_r <= '0;
            state_r <= S_LSQ;
          end else begin
            lx_r <= {lx_r[30:0], 1'b0};
            lk_r <= lk_r - 5'd1;
          end
        end
        S_LSQ: begin
          lm_r    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
          lfrac_r <= {lfrac_r[22:0], sq_top[31]};
          lcnt_r  <= lcnt_r + 5'd1;
          if (lcnt_r == 5'd23) begin
            state_r <= S_LCONV;
          end
        end
        S_LCONV: begin
          lneg_r  <= l_val[29];
          lmag_r  <= l_val[29] ? l_inv : l_val;
          state_r <= S_LLN2;
        end
        S_LLN2: state_r <= S_LRND;
        S_LRND: begin
          lmag_r  <= 30'((prod_r + 64'h8000_0000) >> 32);
          state_r <= S_LMUL;
        end
        S_LMUL: state_r <= S_LTERM;
        S_LTERM: begin
          term_r <= (coef_neg ^ lneg_r) ? term_r + prod_q24 : term_r - prod_q24;
          if (item_r.op == OP_BCE && !ljob_r) begin
            ljob_r  <= 1'b1;
            lx_r    <= larg1;
            lk_r    <= 5'd31;
            state_r <= S_LNORM;
          end else begin
            state_r <= S_GWAIT;
          end
        end
        S_GWAIT: begin
          if (!div_busy) begin
            case (item_r.op)
              OP_CE: begin
                grad_r  <= p_pos ? apply_sign(div_quo, !t_s[31] && t_s != '0) : '0;
                state_r <= S_ACC;
              end
              OP_BCE: begin
                grad_r  <= apply_sign(div_quo, omt[33]);
                state_r <= S_GWAIT2;
              end
              default: begin
                grad_r  <= apply_sign(div_quo, !diff_tp[32] && diff_tp != '0);
                state_r <= S_ACC;
              end
            endcase
          end
        end
        S_GWAIT2: begin
          if (!div_busy) begin
            grad_r  <= grad_r - apply_sign(div_quo, t_s[31]);
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (item_r.fin) begin
            cost_sum_r <= '0;
            csum_neg_r <= sum_nxt[63];
            state_r    <= S_CWAIT;
          end else begin
            cost_sum_r <= sum_nxt;
            cost_r     <= '0;
            state_r    <= S_OUT;
          end
        end
        S_CWAIT: begin
          if (!div_busy) begin
            cost_r  <= cost_nxt;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r  <= {cost_r, sat48(grad_r)};
            out_last_r  <= item_r.fin;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_last_r;
  assign out_tlast  = out_last_r;

  `LGU_ASSERT_NOW(a_div_free, clk, rst_n, div_req.start, !div_busy, "divider restarted while busy")
  `LGU_ASSERT_NOW(a_sum_clear, clk, rst_n, state_r == S_CWAIT, cost_sum_r == '0, "cost sum not cleared after final element")
  `LGU_ASSERT_NEXT(a_out_wait, clk, rst_n, state_r == S_OUT && out_valid_r && !out_tready, state_r == S_OUT, "result overwrote a pending transaction")

endmodule

`default_nettype wire

@@ rtl/core/loss_and_gradient_unit_core.sv @@
// Loss and gradient unit top level: MSE, cross entropy and binary cross entropy.
// One item is worked at a time; the length of its sequence is set by the 64-step divider
// and the 24 squarings of each logarithm. For the final element the back end also divides
// the cost sum by the element count. The back end takes no new item before it has loaded
// the result of the last one into the output register.
// Reset (rst_n low, synchronous) clears the queue, the sequencer, the cost sum and config.
`timescale 1ns / 1ps
`default_nettype none

module loss_and_gradient_unit_core #(
  parameter int unsigned MAX_ELEMENTS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes: index 0 loss_mode, index 1 element_count
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] target_value, [63:32] predicted_value
  input  logic        in_tlast,   // final_element
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [47:0] gradient, [95:48] cost
  output logic        out_tuser,  // [0] cost_valid
  output logic        out_tlast   // last
);
  import lgu_pkg::*;

  lgu_push_t q_wr;
  logic      q_full;
  logic      q_valid;
  lgu_item_t q_item;
  logic      q_pop;

  // Front end: hold config, classify and enqueue each transaction
  lgu_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .wr        (q_wr)
  );

  // Decouple acceptance from the long arithmetic sequence
  lgu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .pop      (q_pop)
  );

  // Back end: gradient, cost term, accumulation and registered result
  lgu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ tb/sv/loss_and_gradient_unit_core_checker.sv @@
`timescale 1ns / 1ps
// Checker for the loss and gradient unit: predicts gradient and cost per transaction.
// Depends on lgu_pkg; watches the config port and both streams of the core.
module loss_and_gradient_unit_core_checker
  import lgu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);

  localparam longint OneQ = 64'sd16777216;
  localparam longint EpQ  = 64'sd2;

  typedef struct {
    logic [47:0] gradient;
    logic [47:0] cost;
    logic        cost_valid;
    logic        last;
  } loss_result_t;

  loss_result_t loss_results_q[$];
  logic [1:0]   mode_reg;
  logic [16:0]  count_reg;
  longint       cost_acc;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint with_sign(longint unsigned m, bit neg);
    if (m > (64'd1 << 62)) m = 64'd1 << 62;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_q24(longint a, longint b);
    return with_sign((magnitude(a) * magnitude(b)) >> 24, (a < 0) != (b < 0));
  endfunction

  // log2 by repeated squaring, then scale by ln 2 in Q0.32 with rounding
  function automatic longint natural_log(longint x);
    longint unsigned u, m, frac;
    int k;
    longint l;
    if (x < 1) x = 1;
    u = x;
    k = 0;
    frac = 0;
    while (k < 62 && (u >> (k + 1)) != 0) k++;
    m = (k >= 30) ? (u >> (k - 30)) : (u << (30 - k));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    l = longint'(k - 24) * OneQ + longint'(frac);
    return with_sign((magnitude(l) * 64'd2977044472 + (64'd1 << 31)) >> 32, l < 0);
  endfunction

  function automatic longint unsigned square_q24(longint d);
    longint unsigned a, hi, lo;
    a = magnitude(d);
    hi = a >> 16;
    lo = a & 64'hFFFF;
    return ((hi * hi) << 8) + ((((64'd2 * hi * lo) << 16) + lo * lo) >> 24);
  endfunction

  function automatic logic [47:0] clamp48(longint v);
    if (v > 64'sd140737488355327) v = 64'sd140737488355327;
    if (v < -64'sd140737488355328) v = -64'sd140737488355328;
    return v[47:0];
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  task automatic report(string what, logic [47:0] want, logic [47:0] got);
    $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    longint t, p, pc, grad, term, a, b;
    longint unsigned n;
    loss_result_t r, want;
    if (!rst_n) begin
      mode_reg  = OP_MSE;
      count_reg = 17'd1;
      cost_acc  = 0;
      loss_results_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgLossMode) mode_reg = cfg_wdata[1:0];
        else count_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        t = $signed(in_tdata[31:0]);
        p = $signed(in_tdata[63:32]);
        n = (count_reg == 0) ? 1 : (count_reg > 65536 ? 65536 : count_reg);
        if (mode_reg == OP_CE) begin
          grad = (p > 0) ? with_sign((magnitude(t) << 24) / (unsigned'(p) * n), t > 0)
                         : 0;
          term = -mul_q24(t, natural_log(p + EpQ));
        end else if (mode_reg == OP_BCE) begin
          // clamp p for the gradient only
          pc = (p < EpQ) ? EpQ : p;
          if (pc > OneQ - EpQ) pc = OneQ - EpQ;
          a = with_sign((magnitude(OneQ - t) << 24) / unsigned'(OneQ - pc),
                        (OneQ - t) < 0);
          b = with_sign((magnitude(t) << 24) / unsigned'(pc), t < 0);
          grad = a - b;
          term = -(mul_q24(t, natural_log(p + EpQ)) +
                   mul_q24(OneQ - t, natural_log(OneQ - p + EpQ)));
        end else begin
          grad = with_sign(magnitude(2 * (p - t)) / n, (p - t) < 0);
          term = longint'(square_q24(t - p));
        end
        cost_acc = sum_sat(cost_acc, term);
        r.gradient   = clamp48(grad);
        r.cost_valid = in_tlast;
        r.last       = in_tlast;
        r.cost       = '0;
        if (in_tlast) begin
          r.cost   = clamp48(with_sign(magnitude(cost_acc) / n, cost_acc < 0));
          cost_acc = 0;
        end
        loss_results_q.push_back(r);
      end
      if (out_tvalid && out_tready) begin
        if (loss_results_q.size() == 0) begin
          report("unexpected result", '0, out_tdata[47:0]);
        end else begin
          want = loss_results_q.pop_front();
          if (out_tdata[47:0] !== want.gradient)
            report("gradient", want.gradient, out_tdata[47:0]);
          if (out_tdata[95:48] !== want.cost) report("cost", want.cost, out_tdata[95:48]);
          if (out_tuser !== want.cost_valid) report("cost_valid", want.cost_valid, out_tuser);
          if (out_tlast !== want.last) report("last", want.last, out_tlast);
        end
      end
    end
    outstanding = loss_results_q.size();
  end

endmodule

@@ tb/sv/loss_and_gradient_unit_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for loss_and_gradient_unit_core: stimulus, idling, pressure and verdict.
// Depends on lgu_pkg, the core RTL and loss_and_gradient_unit_core_checker.
module loss_and_gradient_unit_core_tb;
  import lgu_pkg::*;

  localparam logic [1:0]  ModeSpare = 2'd3;  // unused mode, acts as MSE
  localparam logic [31:0] One       = 32'h0100_0000;
  localparam int          StallLimit = 20000;
  localparam int          HoldCycles = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int mismatches, outstanding;
  int send_idle = 15, recv_idle = 46;
  logic hold_req = 1'b0, hold_done = 1'b0;
  int hold_cnt = 0, quiet_cycles = 0;

  always #4 clk = ~clk;

  loss_and_gradient_unit_core i_dut (.*);

  loss_and_gradient_unit_core_checker i_checker (.*);

  // Receiver: random back-pressure, plus one long hold to fill the core up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_cnt   <= HoldCycles;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: end the run if nothing moves on either stream for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one element; hold valid until the transaction completes.
  task automatic send_pair(logic [31:0] t, logic [31:0] p, logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p, t};
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drain, let the back end settle, then write one register.
  task automatic write_reg(logic idx, logic [16:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix of full-range, probability-range and edge values.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 6))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'd0;
          3: return 32'd1;
          4: return 32'd2;
          5: return One;
          default: return One - 32'd2;
        endcase
      end
      3: return $urandom_range(0, 3 * One) - One;
      default: return $urandom_range(0, One);
    endcase
  endfunction

  function automatic logic [16:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    int sent, len;
    logic [16:0] n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes per mode, clamps, log of non-positive, odd counts.
    write_reg(CfgElemCount, 17'd1);
    send_pair(32'd0, 32'd0, 1'b1);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_pair(One, One - 32'd2, 1'b1);
    write_reg(CfgLossMode, 17'(OP_CE));
    send_pair(One, 32'd0, 1'b1);
    send_pair(One, -32'sd5, 1'b1);
    send_pair(32'h7FFF_FFFF, 32'd1, 1'b1);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    write_reg(CfgLossMode, 17'(OP_BCE));
    send_pair(One >> 1, 32'h7FFF_FFFF, 1'b1);
    send_pair(32'd0, 32'h8000_0000, 1'b1);
    send_pair(One, One >> 1, 1'b1);
    send_pair(32'h8000_0000, 32'd2, 1'b1);
    write_reg(CfgLossMode, 17'(ModeSpare));
    write_reg(CfgElemCount, 17'd0);
    send_pair(One, 32'd0, 1'b1);
    write_reg(CfgLossMode, 17'(OP_MSE));
    write_reg(CfgElemCount, 17'h1FFFF);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // Change mode between elements of one tensor: the running sum carries over.
    write_reg(CfgLossMode, 17'(OP_CE));
    write_reg(CfgElemCount, 17'd2);
    send_pair(One, One >> 2, 1'b0);
    write_reg(CfgLossMode, 17'(OP_BCE));
    send_pair(One >> 1, One >> 1, 1'b1);

    // Random phases: four per idling regime.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle = 46;
        recv_idle = 15;
      end else if (ph == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CfgLossMode, 17'($urandom_range(0, 3)));
      n = pick_count();
      write_reg(CfgElemCount, n);
      if (ph == 0) hold_req <= 1'b1;  // long receiver hold while we keep offering
      sent = 0;
      while (sent < 40) begin
        // mostly whole tensors of N; large or zero N and a few broken ones use short runs
        if (n >= 1 && n <= 8 && $urandom_range(0, 9) != 0) len = n;
        else len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_pair(pick_value(), pick_value(), i == len - 1);
          sent++;
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lgu_pkg.sv
rtl/core/lgu_front.sv
rtl/core/lgu_queue.sv
rtl/core/lgu_div.sv
rtl/core/lgu_back.sv
rtl/core/loss_and_gradient_unit_core.sv
tb/sv/loss_and_gradient_unit_core_checker.sv
tb/sv/loss_and_gradient_unit_core_tb.sv
